FILE: sv/ctsb_pkg.sv
// Shared types and constants for the sphere/box contact test pipeline.
`timescale 1ns / 1ps
package ctsb_pkg;

   localparam int SqrtSteps = 32;
   localparam int QuotBits  = 15;
   localparam int NormShift = 14;
   localparam int RemBits   = 47;

   localparam logic [15:0] NormOne  = 16'd16384;
   localparam logic [30:0] DepthMax = 31'h7FFF_FFFF;

   // Box-box axis codes in tie order
   localparam logic [2:0] AxisPosX = 3'd0;
   localparam logic [2:0] AxisNegX = 3'd1;
   localparam logic [2:0] AxisPosY = 3'd2;
   localparam logic [2:0] AxisNegY = 3'd3;
   localparam logic [2:0] AxisPosZ = 3'd4;
   localparam logic [2:0] AxisNegZ = 3'd5;

   typedef struct packed {
      logic               first_kind;
      logic               second_kind;
      logic signed [31:0] offset_x;
      logic signed [31:0] offset_y;
      logic signed [31:0] offset_z;
      logic [29:0]        first_size_x;
      logic [29:0]        first_size_y;
      logic [29:0]        first_size_z;
      logic [29:0]        second_size_x;
      logic [29:0]        second_size_y;
      logic [29:0]        second_size_z;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic [30:0]        depth;
   } rsp_type;

   // Per-item data that rides along the pipeline
   typedef struct packed {
      logic             round_path;
      logic [2:0]       neg;
      logic [30:0]      radius;
      logic [2:0][31:0] mag;
      logic             bb_hit;
      logic [2:0]       bb_axis;
      logic [30:0]      bb_depth;
   } side_type;

   // Unit normal of a box-box axis code, one component at a time
   function automatic logic [15:0] axis_comp(input logic [2:0] axis, input logic [1:0] comp);
      logic [15:0] v;
      v = '0;
      unique case (axis)
         AxisPosX: v = (comp == 2'd0) ? NormOne : 16'd0;
         AxisNegX: v = (comp == 2'd0) ? (16'd0 - NormOne) : 16'd0;
         AxisPosY: v = (comp == 2'd1) ? NormOne : 16'd0;
         AxisNegY: v = (comp == 2'd1) ? (16'd0 - NormOne) : 16'd0;
         AxisPosZ: v = (comp == 2'd2) ? NormOne : 16'd0;
         AxisNegZ: v = (comp == 2'd2) ? (16'd0 - NormOne) : 16'd0;
         default:  v = 16'd0;
      endcase
      return v;
   endfunction

endpackage

FILE: sv/ctsb_front.sv
// Front stages: difference vector, box-box overlap, squares and their sum.
`timescale 1ns / 1ps
module ctsb_front import ctsb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  req_type     in_data,
   output logic        out_valid,
   output side_type    out_side,
   output logic [63:0] out_sum
);

   logic                   ka, kb;
   logic signed [2:0][31:0] o;
   logic [2:0][29:0]       ha, hb, hbox;
   logic [29:0]            sph_r;
   logic signed [33:0]     p, c, d, hs;
   logic [2:0][31:0]       mag_in;
   logic [2:0]             neg_in;
   logic [30:0]            radius_in;
   logic [2:0][33:0]       lo_in, hi_in;
   logic [30:0]            hsum;

   // stage A registers
   logic             a_valid_ff;
   logic             a_round_ff;
   logic [2:0]       a_neg_ff;
   logic [30:0]      a_radius_ff;
   logic [2:0][31:0] a_mag_ff;
   logic [2:0][33:0] a_lo_ff, a_hi_ff;

   // stage B
   logic             b_valid_ff;
   side_type         b_side_ff, b_side_in;
   logic [2:0][63:0] b_sq_ff, b_sq_in;
   logic signed [33:0] best, lo_k, hi_k;
   logic [2:0]       axis;
   logic             any_neg;

   // stage C
   logic             c_valid_ff;
   side_type         c_side_ff;
   logic [63:0]      c_sum_ff;

   // Build difference vector, radius and box-box spans
   always_comb begin
      ka = in_data.first_kind;
      kb = in_data.second_kind;
      o[0] = in_data.offset_x;
      o[1] = in_data.offset_y;
      o[2] = in_data.offset_z;
      ha[0] = in_data.first_size_x;
      ha[1] = in_data.first_size_y;
      ha[2] = in_data.first_size_z;
      hb[0] = in_data.second_size_x;
      hb[1] = in_data.second_size_y;
      hb[2] = in_data.second_size_z;
      hbox = ka ? ha : hb;
      sph_r = ka ? hb[0] : ha[0];
      radius_in = (!ka && !kb) ? (31'(ha[0]) + 31'(hb[0])) : 31'(sph_r);
      for (int k = 0; k < 3; k++) begin
         hsum = 31'(ha[k]) + 31'(hb[k]);
         lo_in[k] = $signed({3'b000, hsum}) - 34'($signed(o[k]));
         hi_in[k] = $signed({3'b000, hsum}) + 34'($signed(o[k]));
         hs = $signed({4'b0000, hbox[k]});
         p = ka ? 34'($signed(o[k])) : (34'sd0 - 34'($signed(o[k])));
         if (p < -hs) begin
            c = -hs;
         end else if (p > hs) begin
            c = hs;
         end else begin
            c = p;
         end
         d = (!ka && !kb) ? 34'($signed(o[k])) : (p - c);
         mag_in[k] = d[33] ? 32'(34'sd0 - d) : d[31:0];
         neg_in[k] = d[33] ^ ~ka;
      end
   end

   // Pick least-overlap axis and square the magnitudes
   always_comb begin
      best = $signed(a_lo_ff[0]);
      axis = AxisPosX;
      any_neg = 1'b0;
      for (int k = 0; k < 3; k++) begin
         lo_k = $signed(a_lo_ff[k]);
         hi_k = $signed(a_hi_ff[k]);
         any_neg = any_neg | lo_k[33] | hi_k[33];
         if (k == 0 || lo_k < best) begin
            best = lo_k;
            axis = 3'(2 * k);
         end
         if (hi_k < best) begin
            best = hi_k;
            axis = 3'(2 * k + 1);
         end
      end
      b_side_in.round_path = a_round_ff;
      b_side_in.neg        = a_neg_ff;
      b_side_in.radius     = a_radius_ff;
      b_side_in.mag        = a_mag_ff;
      b_side_in.bb_hit     = !any_neg && (best > 34'sd0);
      b_side_in.bb_axis    = axis;
      b_side_in.bb_depth   = (best > $signed({3'b000, DepthMax})) ? DepthMax : best[30:0];
      for (int k = 0; k < 3; k++) begin
         b_sq_in[k] = a_mag_ff[k] * a_mag_ff[k];
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         a_round_ff  <= !(ka && kb);
         a_neg_ff    <= neg_in;
         a_radius_ff <= radius_in;
         a_mag_ff    <= mag_in;
         a_lo_ff     <= lo_in;
         a_hi_ff     <= hi_in;
         b_side_ff   <= b_side_in;
         b_sq_ff     <= b_sq_in;
         c_side_ff   <= b_side_ff;
         c_sum_ff    <= b_sq_ff[0] + b_sq_ff[1] + b_sq_ff[2];
      end
   end

   assign out_valid = c_valid_ff;
   assign out_side  = c_side_ff;
   assign out_sum   = c_sum_ff;

endmodule

FILE: sv/ctsb_sqrt.sv
// Integer square root, one result bit per pipeline stage.
`timescale 1ns / 1ps
module ctsb_sqrt import ctsb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  side_type    in_side,
   input  logic [63:0] in_sum,
   output logic        out_valid,
   output side_type    out_side,
   output logic [31:0] out_dist
);

   logic [63:0] x_ff [SqrtSteps];
   logic [63:0] x_in [SqrtSteps];
   logic [63:0] r_ff [SqrtSteps];
   logic [63:0] r_in [SqrtSteps];
   side_type    side_ff [SqrtSteps];
   logic [SqrtSteps-1:0] valid_ff;

   for (genvar i = 0; i < SqrtSteps; i++) begin : g_step
      localparam logic [63:0] StepBit = 64'(1) << (62 - 2 * i);
      logic [63:0] x_prev, r_prev;
      logic [64:0] trial;
      side_type    side_prev;
      logic        valid_prev;

      if (i == 0) begin : g_first
         assign x_prev     = in_sum;
         assign r_prev     = '0;
         assign side_prev  = in_side;
         assign valid_prev = in_valid;
      end else begin : g_rest
         assign x_prev     = x_ff[i-1];
         assign r_prev     = r_ff[i-1];
         assign side_prev  = side_ff[i-1];
         assign valid_prev = valid_ff[i-1];
      end

      // Try to take this bit of the root
      always_comb begin
         trial = {1'b0, r_prev} + {1'b0, StepBit};
         if ({1'b0, x_prev} >= trial) begin
            x_in[i] = x_prev - trial[63:0];
            r_in[i] = (r_prev >> 1) + StepBit;
         end else begin
            x_in[i] = x_prev;
            r_in[i] = r_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i]    <= x_in[i];
            r_ff[i]    <= r_in[i];
            side_ff[i] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[SqrtSteps-1];
   assign out_side  = side_ff[SqrtSteps-1];
   assign out_dist  = r_ff[SqrtSteps-1][31:0];

endmodule

FILE: sv/ctsb_div.sv
// Contact check and normal division, one quotient bit per stage per lane.
`timescale 1ns / 1ps
module ctsb_div import ctsb_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  side_type                in_side,
   input  logic [31:0]             in_dist,
   output logic                    out_valid,
   output side_type                out_side,
   output logic                    out_rhit,
   output logic [30:0]             out_rdepth,
   output logic [2:0][QuotBits-1:0] out_quot
);

   // setup stage
   logic                    s_valid_ff;
   side_type                s_side_ff;
   logic [31:0]             s_dist_ff;
   logic                    s_rhit_ff, s_rhit_in;
   logic [30:0]             s_rdepth_ff, s_rdepth_in;
   logic [2:0][RemBits-1:0] s_rem_ff, s_rem_in;

   // divide stages
   logic [QuotBits-1:0]              valid_ff;
   side_type                         side_ff [QuotBits];
   logic [31:0]                      dist_ff [QuotBits];
   logic                             rhit_ff [QuotBits];
   logic [30:0]                      rdepth_ff [QuotBits];
   logic [2:0][RemBits-1:0]          rem_ff [QuotBits];
   logic [2:0][RemBits-1:0]          rem_in [QuotBits];
   logic [2:0][QuotBits-1:0]         quot_ff [QuotBits];
   logic [2:0][QuotBits-1:0]         quot_in [QuotBits];

   // Compare distance with radius, form rounded numerators
   always_comb begin
      s_rhit_in   = (in_dist != 32'd0) && ({1'b0, in_side.radius} > in_dist);
      s_rdepth_in = in_side.radius - in_dist[30:0];
      for (int k = 0; k < 3; k++) begin
         s_rem_in[k] = (RemBits'(in_side.mag[k]) << NormShift) + RemBits'(in_dist >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else if (en) begin
         s_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_side_ff   <= in_side;
         s_dist_ff   <= in_dist;
         s_rhit_ff   <= s_rhit_in;
         s_rdepth_ff <= s_rdepth_in;
         s_rem_ff    <= s_rem_in;
      end
   end

   for (genvar j = 0; j < QuotBits; j++) begin : g_step
      localparam int Shift = QuotBits - 1 - j;
      logic [RemBits-1:0]       divisor;
      logic [2:0][RemBits-1:0]  rem_prev;
      logic [2:0][QuotBits-1:0] quot_prev;
      logic [31:0]              dist_prev;
      side_type                 side_prev;
      logic                     rhit_prev, valid_prev;
      logic [30:0]              rdepth_prev;

      if (j == 0) begin : g_first
         assign rem_prev    = s_rem_ff;
         assign quot_prev   = '0;
         assign dist_prev   = s_dist_ff;
         assign side_prev   = s_side_ff;
         assign rhit_prev   = s_rhit_ff;
         assign rdepth_prev = s_rdepth_ff;
         assign valid_prev  = s_valid_ff;
      end else begin : g_rest
         assign rem_prev    = rem_ff[j-1];
         assign quot_prev   = quot_ff[j-1];
         assign dist_prev   = dist_ff[j-1];
         assign side_prev   = side_ff[j-1];
         assign rhit_prev   = rhit_ff[j-1];
         assign rdepth_prev = rdepth_ff[j-1];
         assign valid_prev  = valid_ff[j-1];
      end

      // Subtract the shifted divisor where it fits
      always_comb begin
         divisor = RemBits'(dist_prev) << Shift;
         for (int k = 0; k < 3; k++) begin
            if (rem_prev[k] >= divisor) begin
               rem_in[j][k]  = rem_prev[k] - divisor;
               quot_in[j][k] = {quot_prev[k][QuotBits-2:0], 1'b1};
            end else begin
               rem_in[j][k]  = rem_prev[k];
               quot_in[j][k] = {quot_prev[k][QuotBits-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (en) begin
            valid_ff[j] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]    <= rem_in[j];
            quot_ff[j]   <= quot_in[j];
            dist_ff[j]   <= dist_prev;
            side_ff[j]   <= side_prev;
            rhit_ff[j]   <= rhit_prev;
            rdepth_ff[j] <= rdepth_prev;
         end
      end
   end

   assign out_valid  = valid_ff[QuotBits-1];
   assign out_side   = side_ff[QuotBits-1];
   assign out_rhit   = rhit_ff[QuotBits-1];
   assign out_rdepth = rdepth_ff[QuotBits-1];
   assign out_quot   = quot_ff[QuotBits-1];

endmodule

FILE: sv/contact_test_sphere_box.sv
// Depth: 52 register stages; a valid response beat is taken at an edge with rsp_ready high.
// Throughput: one pair per cycle unless the response is stalled; 3 front stages,
// 32 square-root stages, one setup stage plus 15 divide stages and one output register
// set the depth. A stalled response holds the whole pipeline in place.
// Synchronous active-high reset clears all valid bits; no clearing pass.
`timescale 1ns / 1ps
module contact_test_sphere_box import ctsb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic                     en;
   logic                     f_valid, q_valid, d_valid;
   side_type                 f_side, q_side, d_side;
   logic [63:0]              f_sum;
   logic [31:0]              q_dist;
   logic                     d_rhit;
   logic [30:0]              d_rdepth;
   logic [2:0][QuotBits-1:0] d_quot;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_data_ff, rsp_data_in;
   logic [2:0][15:0]         norm;
   logic [15:0]              qc;

   // Move the whole pipeline when the output slot frees up
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   ctsb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (f_valid),
      .out_side  (f_side),
      .out_sum   (f_sum)
   );

   ctsb_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .in_side   (f_side),
      .in_sum    (f_sum),
      .out_valid (q_valid),
      .out_side  (q_side),
      .out_dist  (q_dist)
   );

   ctsb_div u_div (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (q_valid),
      .in_side    (q_side),
      .in_dist    (q_dist),
      .out_valid  (d_valid),
      .out_side   (d_side),
      .out_rhit   (d_rhit),
      .out_rdepth (d_rdepth),
      .out_quot   (d_quot)
   );

   // Assemble the result beat
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         qc = ({1'b0, d_quot[k]} > NormOne) ? NormOne : {1'b0, d_quot[k]};
         if (d_side.round_path) begin
            norm[k] = !d_rhit ? 16'd0 : (d_side.neg[k] ? (16'd0 - qc) : qc);
         end else begin
            norm[k] = d_side.bb_hit ? axis_comp(d_side.bb_axis, 2'(k)) : 16'd0;
         end
      end
      if (d_side.round_path) begin
         rsp_data_in.hit   = d_rhit;
         rsp_data_in.depth = d_rhit ? d_rdepth : 31'd0;
      end else begin
         rsp_data_in.hit   = d_side.bb_hit;
         rsp_data_in.depth = d_side.bb_hit ? d_side.bb_depth : 31'd0;
      end
      rsp_data_in.normal_x = $signed(norm[0]);
      rsp_data_in.normal_y = $signed(norm[1]);
      rsp_data_in.normal_z = $signed(norm[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
